FILE: src/ptwa_pkg.sv
// ----------------------------------------------------------------------------
// ptwa_pkg
// Shared constants and codes for the peer table with aging and routes.
// ----------------------------------------------------------------------------
package ptwa_pkg;

	localparam int unsigned PEER_SLOTS_DEF  = 32;
	localparam int unsigned ROUTE_SLOTS_DEF = 32;
	localparam int unsigned KEY_BITS_DEF    = 64;

	localparam logic [31:0] AGE_LIMIT_RESET = 32'd60000;

	// Operation codes carried on the action input.
	localparam logic [2:0] ACT_INSERT  = 3'd0;
	localparam logic [2:0] ACT_TOUCH   = 3'd1;
	localparam logic [2:0] ACT_REMOVE  = 3'd2;
	localparam logic [2:0] ACT_LOOKUP  = 3'd3;
	localparam logic [2:0] ACT_SWEEP   = 3'd4;
	localparam logic [2:0] ACT_DEST    = 3'd5;
	localparam logic [2:0] ACT_WRROUTE = 3'd6;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// Register index of the age limit on the configuration port.
	localparam logic REG_AGE_LIMIT = 1'b0;

endpackage

FILE: src/ptwa_ram.sv
// ----------------------------------------------------------------------------
// ptwa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ptwa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/peer_table_with_aging_and_routes_top.sv
// ----------------------------------------------------------------------------
// peer_table_with_aging_and_routes_top
// Peer table with aging, key lookup and address-to-destination routing.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears for one cycle with done high and cannot be stalled. Insert, write
// route and unused codes answer in the cycle after they are taken. Touch and
// age sweep walk every peer slot, reading and then examining each slot;
// remove and lookup stop at the first match. Destination resolution walks
// the peer slots and, for each address match, the route table and then the
// peer table again. The pace is set by the single read port of each table
// RAM, whose read is registered: each entry is read in S_PRD, S_RRD or S_KRD
// and examined in S_PEV, S_REV or S_KEV.
// ----------------------------------------------------------------------------
module peer_table_with_aging_and_routes_top #(
	parameter int unsigned PEER_SLOTS  = ptwa_pkg::PEER_SLOTS_DEF,
	parameter int unsigned ROUTE_SLOTS = ptwa_pkg::ROUTE_SLOTS_DEF,
	parameter int unsigned KEY_BITS    = ptwa_pkg::KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [63:0] entry_key,
	input  logic [63:0] peer_key,
	input  logic [31:0] ip_addr,
	input  logic [15:0] udp_port,
	input  logic [31:0] now_ms,
	input  logic [4:0]  route_slot,
	output logic        done,
	output logic        hit,
	output logic [1:0]  status,
	output logic [4:0]  slot_index,
	output logic [63:0] found_key,
	output logic [31:0] found_ip,
	output logic [15:0] found_port,
	output logic [5:0]  removed_count
);

	localparam int unsigned PIW = $clog2(PEER_SLOTS);
	localparam int unsigned RIW = $clog2(ROUTE_SLOTS);
	localparam int unsigned CW  = $clog2(PEER_SLOTS + 1);
	localparam int unsigned PW  = KEY_BITS + 80;
	localparam int unsigned RW  = 2 * KEY_BITS;
	localparam logic [PIW-1:0] PLAST = PIW'(PEER_SLOTS - 1);
	localparam logic [RIW-1:0] RLAST = RIW'(ROUTE_SLOTS - 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PRD  = 7'b0000010,
		S_PEV  = 7'b0000100,
		S_RRD  = 7'b0001000,
		S_REV  = 7'b0010000,
		S_KRD  = 7'b0100000,
		S_KEV  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [2:0]          act_q;
	logic [KEY_BITS-1:0] key_q, cur_key_q, dst_q;
	logic [31:0]         ip_q, now_q, limit_q;
	logic [15:0]         port_q;
	logic [PIW-1:0]      p_idx_q, k_idx_q, first_q;
	logic [RIW-1:0]      r_idx_q;
	logic                found_q;
	logic [CW-1:0]       cnt_q;
	logic [PEER_SLOTS-1:0]  valid_q;
	logic [ROUTE_SLOTS-1:0] rvalid_q;

	logic                done_q, hit_q;
	logic [1:0]          status_q;
	logic [4:0]          slot_q;
	logic [63:0]         fkey_q;
	logic [31:0]         fip_q;
	logic [15:0]         fport_q;
	logic [5:0]          rcnt_q;

	logic                pram_we, rram_we;
	logic [PIW-1:0]      pram_waddr, pram_raddr;
	logic [RIW-1:0]      rram_waddr;
	logic [PW-1:0]       pram_wdata, pram_rdata;
	logic [RW-1:0]       rram_wdata, rram_rdata;

	logic [KEY_BITS-1:0] in_key, pe_key, re_src, re_dst;
	logic [31:0]         pe_ip, pe_stamp, age;
	logic [15:0]         pe_port;
	logic                free_found, accept, p_match, r_match, k_match, rs_ok;
	logic [PIW-1:0]      free_idx;

	assign in_key   = entry_key[KEY_BITS-1:0];
	assign pe_key   = pram_rdata[PW-1:80];
	assign pe_ip    = pram_rdata[79:48];
	assign pe_port  = pram_rdata[47:32];
	assign pe_stamp = pram_rdata[31:0];
	assign re_src   = rram_rdata[RW-1:KEY_BITS];
	assign re_dst   = rram_rdata[KEY_BITS-1:0];
	assign age      = now_q - pe_stamp;
	assign accept   = start && (state_q == S_IDLE);
	assign p_match  = valid_q[p_idx_q] && (pe_key == key_q);
	assign r_match  = rvalid_q[r_idx_q] && (re_src == cur_key_q);
	assign k_match  = valid_q[k_idx_q] && (pe_key == dst_q);
	assign rs_ok    = 32'(route_slot) < 32'(ROUTE_SLOTS);

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = PIW'(i);
			end
		end
	end

	always_comb begin
		pram_we    = 1'b0;
		pram_waddr = p_idx_q;
		pram_wdata = {key_q, ip_q, port_q, now_q};
		if (accept && action == ptwa_pkg::ACT_INSERT && free_found) begin
			pram_we    = 1'b1;
			pram_waddr = free_idx;
			pram_wdata = {in_key, ip_addr, udp_port, now_ms};
		end else if (state_q == S_PEV && act_q == ptwa_pkg::ACT_TOUCH && p_match) begin
			pram_we = 1'b1;
		end
	end

	assign pram_raddr = (state_q == S_KRD) ? k_idx_q : p_idx_q;
	assign rram_we    = accept && action == ptwa_pkg::ACT_WRROUTE && rs_ok;
	assign rram_waddr = RIW'(route_slot);
	assign rram_wdata = {in_key, peer_key[KEY_BITS-1:0]};

	ptwa_ram #(.WIDTH(PW), .DEPTH(PEER_SLOTS)) u_peer_ram (
		.clk   (clk),
		.we    (pram_we),
		.waddr (pram_waddr),
		.wdata (pram_wdata),
		.raddr (pram_raddr),
		.rdata (pram_rdata)
	);

	ptwa_ram #(.WIDTH(RW), .DEPTH(ROUTE_SLOTS)) u_route_ram (
		.clk   (clk),
		.we    (rram_we),
		.waddr (rram_waddr),
		.wdata (rram_wdata),
		.raddr (r_idx_q),
		.rdata (rram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ptwa_pkg::AGE_LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == ptwa_pkg::REG_AGE_LIMIT) begin
			limit_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ptwa_pkg::REG_AGE_LIMIT) ? limit_q : 32'd0;

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action;
			key_q  <= in_key;
			ip_q   <= ip_addr;
			port_q <= udp_port;
			now_q  <= now_ms;
		end
		if (state_q == S_PEV) begin
			cur_key_q <= pe_key;
		end
		if (state_q == S_REV) begin
			dst_q <= re_dst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			rvalid_q <= '0;
			done_q   <= 1'b0;
			p_idx_q  <= '0;
			k_idx_q  <= '0;
			r_idx_q  <= '0;
			first_q  <= '0;
			found_q  <= 1'b0;
			cnt_q    <= '0;
			hit_q    <= 1'b0;
			status_q <= ptwa_pkg::ST_OK;
			slot_q   <= '0;
			fkey_q   <= '0;
			fip_q    <= '0;
			fport_q  <= '0;
			rcnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					p_idx_q <= '0;
					found_q <= 1'b0;
					cnt_q   <= '0;
					if (start) begin
						hit_q    <= 1'b0;
						status_q <= ptwa_pkg::ST_OK;
						slot_q   <= '0;
						fkey_q   <= '0;
						fip_q    <= '0;
						fport_q  <= '0;
						rcnt_q   <= '0;
						if (action == ptwa_pkg::ACT_INSERT) begin
							done_q <= 1'b1;
							if (free_found) begin
								valid_q[free_idx] <= 1'b1;
								hit_q   <= 1'b1;
								slot_q  <= 5'(free_idx);
								fkey_q  <= 64'(in_key);
								fip_q   <= ip_addr;
								fport_q <= udp_port;
							end else begin
								status_q <= ptwa_pkg::ST_FULL;
							end
						end else if (action == ptwa_pkg::ACT_WRROUTE) begin
							done_q <= 1'b1;
							slot_q <= route_slot;
							if (rs_ok) begin
								rvalid_q[RIW'(route_slot)] <= 1'b1;
							end
						end else if (action == ptwa_pkg::ACT_TOUCH
								|| action == ptwa_pkg::ACT_REMOVE
								|| action == ptwa_pkg::ACT_LOOKUP
								|| action == ptwa_pkg::ACT_SWEEP
								|| action == ptwa_pkg::ACT_DEST) begin
							state_q <= S_PRD;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_PRD: begin
					state_q <= S_PEV;
				end
				S_PEV: begin
					state_q <= S_PRD;
					p_idx_q <= p_idx_q + 1'b1;
					case (act_q)
						ptwa_pkg::ACT_TOUCH: begin
							if (p_match && !found_q) begin
								found_q <= 1'b1;
								first_q <= p_idx_q;
							end
							if (p_idx_q == PLAST) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
								if (found_q || p_match) begin
									hit_q   <= 1'b1;
									slot_q  <= found_q ? 5'(first_q) : 5'(p_idx_q);
									fkey_q  <= 64'(key_q);
									fip_q   <= ip_q;
									fport_q <= port_q;
								end else begin
									status_q <= ptwa_pkg::ST_NOT_FOUND;
								end
							end
						end
						ptwa_pkg::ACT_REMOVE, ptwa_pkg::ACT_LOOKUP: begin
							if (p_match) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
								hit_q   <= 1'b1;
								slot_q  <= 5'(p_idx_q);
								fkey_q  <= 64'(pe_key);
								fip_q   <= pe_ip;
								fport_q <= pe_port;
								if (act_q == ptwa_pkg::ACT_REMOVE) begin
									valid_q[p_idx_q] <= 1'b0;
								end
							end else if (p_idx_q == PLAST) begin
								state_q  <= S_IDLE;
								done_q   <= 1'b1;
								status_q <= ptwa_pkg::ST_NOT_FOUND;
							end
						end
						ptwa_pkg::ACT_SWEEP: begin
							if (valid_q[p_idx_q] && age > limit_q) begin
								valid_q[p_idx_q] <= 1'b0;
							end
							cnt_q <= cnt_q + CW'(valid_q[p_idx_q] && age > limit_q);
							if (p_idx_q == PLAST) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
								rcnt_q  <= 6'(cnt_q + CW'(valid_q[p_idx_q] && age > limit_q));
							end
						end
						default: begin
							// Destination: an address match starts the route search.
							if (valid_q[p_idx_q] && pe_ip == ip_q && pe_port == port_q) begin
								state_q <= S_RRD;
								p_idx_q <= p_idx_q;
								r_idx_q <= '0;
							end else if (p_idx_q == PLAST) begin
								state_q  <= S_IDLE;
								done_q   <= 1'b1;
								status_q <= ptwa_pkg::ST_NOT_FOUND;
							end
						end
					endcase
				end
				S_RRD: begin
					state_q <= S_REV;
				end
				S_REV: begin
					if (r_match) begin
						state_q <= S_KRD;
						k_idx_q <= '0;
					end else if (r_idx_q == RLAST) begin
						// No route for this sender; try the next address match.
						if (p_idx_q == PLAST) begin
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
							status_q <= ptwa_pkg::ST_NOT_FOUND;
						end else begin
							state_q <= S_PRD;
							p_idx_q <= p_idx_q + 1'b1;
						end
					end else begin
						state_q <= S_RRD;
						r_idx_q <= r_idx_q + 1'b1;
					end
				end
				S_KRD: begin
					state_q <= S_KEV;
				end
				S_KEV: begin
					if (k_match) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						hit_q   <= 1'b1;
						slot_q  <= 5'(k_idx_q);
						fkey_q  <= 64'(pe_key);
						fip_q   <= pe_ip;
						fport_q <= pe_port;
					end else if (k_idx_q == PLAST) begin
						if (p_idx_q == PLAST) begin
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
							status_q <= ptwa_pkg::ST_NOT_FOUND;
						end else begin
							state_q <= S_PRD;
							p_idx_q <= p_idx_q + 1'b1;
						end
					end else begin
						state_q <= S_KRD;
						k_idx_q <= k_idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign hit           = hit_q;
	assign status        = status_q;
	assign slot_index    = slot_q;
	assign found_key     = fkey_q;
	assign found_ip      = fip_q;
	assign found_port    = fport_q;
	assign removed_count = rcnt_q;

endmodule

FILE: src/ptwa_checker.sv
// ----------------------------------------------------------------------------
// ptwa_checker
// Port-level checks on the peer table, bound to the top level.
// ----------------------------------------------------------------------------
module ptwa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [2:0] action,
	input logic       done,
	input logic       hit,
	input logic [1:0] status,
	input logic [5:0] removed_count
);

	// A found entry always reports success.
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> status == ptwa_pkg::ST_OK)
		else $error("hit with a failing status");

	// A failing item carries no hit and no sweep count.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ptwa_pkg::ST_OK |-> !hit && removed_count == 6'd0)
		else $error("failing result carries data");

	// Insert and route writes answer in the following cycle without going busy.
	a_fast_ops: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (action == ptwa_pkg::ACT_INSERT || action == ptwa_pkg::ACT_WRROUTE)
		|=> done && !busy)
		else $error("single-cycle item did not answer");

	// Every result follows an accepted item or scan work.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result without an item");

endmodule

bind peer_table_with_aging_and_routes_top ptwa_checker u_ptwa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.action        (action),
	.done          (done),
	.hit           (hit),
	.status        (status),
	.removed_count (removed_count)
);
